// ===== sv/shs_pkg.sv =====
// Package for the stepper homing sequencer: write-register codes, config
// register indexes, reset values and the structs shared by the modules.
// No dependencies.
package shs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SPEED_W    = 23;
    localparam int WAIT_W     = 16;
    localparam int MAX_WR     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOMING_SPEED   = 3'd0,
        CFG_RUN_SPEED      = 3'd1,
        CFG_BACKOFF_TARGET = 3'd2,
        CFG_SEARCH_TARGET  = 3'd3,
        CFG_PARK_TARGET    = 3'd4,
        CFG_WAIT_TICKS     = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_MOVE  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        WR_NONE = 3'd0,
        WR_VMAX = 3'd1,
        WR_TGT  = 3'd2,
        WR_RAMP = 3'd3,
        WR_XACT = 3'd4
    } t_wreg;

    localparam logic [31:0] RAMP_POSITION = 32'd0;
    localparam logic [31:0] RAMP_HOLD     = 32'd3;

    localparam logic [SPEED_W-1:0] RST_HOMING_SPEED   = 23'd4000;
    localparam logic [SPEED_W-1:0] RST_RUN_SPEED      = 23'd100000;
    localparam logic [31:0]        RST_BACKOFF_TARGET = 32'sd1000;
    localparam logic [31:0]        RST_SEARCH_TARGET  = -32'sd30000;
    localparam logic [31:0]        RST_PARK_TARGET    = 32'sd6800;
    localparam logic [WAIT_W-1:0]  RST_WAIT_TICKS     = 16'd1000;

    typedef struct packed {
        logic [SPEED_W-1:0] homing_speed;
        logic [SPEED_W-1:0] run_speed;
        logic signed [31:0] backoff_target;
        logic signed [31:0] search_target;
        logic signed [31:0] park_target;
        logic [WAIT_W-1:0]  wait_ticks;
    } t_cfg;

    typedef struct packed {
        t_wreg              reg_sel;
        logic signed [31:0] value;
    } t_write;

    // All results of one request, plus the status reported with each.
    typedef struct packed {
        t_write [MAX_WR-1:0] wr;
        logic [1:0]          last_idx;
        logic                busy;
        logic signed [31:0]  cmd_pos;
    } t_bundle;

endpackage

// ===== sv/shs_req_if.sv =====
// Request channel of the homing sequencer: valid/ready plus the input fields.
// No dependencies.
interface shs_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] move_target;
    logic               at_left_stop;
    logic               speed_is_zero;
    logic signed [31:0] actual_pos;
    logic signed [31:0] latched_pos;

    modport source (output valid, kind, move_target, at_left_stop, speed_is_zero,
                    actual_pos, latched_pos, input ready);
    modport sink   (input valid, kind, move_target, at_left_stop, speed_is_zero,
                    actual_pos, latched_pos, output ready);
endinterface

// ===== sv/shs_res_if.sv =====
// Result channel of the homing sequencer: valid/ready plus the result fields.
// No dependencies.
interface shs_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         write_reg;
    logic signed [31:0] write_value;
    logic               last;
    logic               homing_busy;
    logic signed [31:0] commanded_pos;

    modport source (output valid, write_reg, write_value, last, homing_busy,
                    commanded_pos, input ready);
    modport sink   (input valid, write_reg, write_value, last, homing_busy,
                    commanded_pos, output ready);
endinterface

// ===== sv/shs_step.sv =====
// Homing state machine: holds phase, tick counter and last move target, and
// computes the register writes of one request. Depends on shs_pkg.
module shs_step
    import shs_pkg::*;
#(
    parameter int COUNTER_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_move_target,
    input  logic               i_at_left_stop,
    input  logic               i_speed_is_zero,
    input  logic signed [31:0] i_actual_pos,
    input  logic signed [31:0] i_latched_pos,
    input  t_cfg               i_cfg,
    output t_bundle            o_bundle
);

    localparam int CW = (COUNTER_BITS > WAIT_W) ? COUNTER_BITS : WAIT_W;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_BACK   = 3'd2,
        PH_SEARCH = 3'd3,
        PH_SETTLE = 3'd4
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [COUNTER_BITS-1:0] r_cnt, n_cnt;
    logic signed [31:0]      r_tgt, n_tgt;

    logic [CW-1:0] w_cnt_ext, w_wait_ext, w_max_ext;
    logic          w_wait_done;

    assign w_cnt_ext   = CW'(r_cnt);
    assign w_wait_ext  = CW'(i_cfg.wait_ticks);
    assign w_max_ext   = CW'({COUNTER_BITS{1'b1}});
    assign w_wait_done = w_cnt_ext > w_wait_ext;

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_tgt    = r_tgt;
        o_bundle = '0;
        unique case (i_kind)
            KIND_TICK: begin
                unique case (r_phase)
                    PH_IDLE: begin
                    end
                    PH_START: begin
                        o_bundle.wr[0] = '{WR_VMAX, 32'(i_cfg.homing_speed)};
                        if (i_at_left_stop) begin
                            n_cnt          = '0;
                            o_bundle.wr[1] = '{WR_TGT, i_cfg.backoff_target};
                            o_bundle.last_idx = 2'd1;
                        end else begin
                            // skip the back-off wait, clipped to the counter range
                            n_cnt = (w_wait_ext < w_max_ext) ?
                                    w_wait_ext[COUNTER_BITS-1:0] : {COUNTER_BITS{1'b1}};
                        end
                        n_phase = PH_BACK;
                    end
                    PH_BACK: begin
                        if (w_wait_done) begin
                            o_bundle.wr[0] = '{WR_TGT, i_cfg.search_target};
                            n_cnt          = '0;
                            n_phase        = PH_SEARCH;
                        end
                    end
                    PH_SEARCH: begin
                        if (i_speed_is_zero) begin
                            n_cnt          = '0;
                            o_bundle.wr[0] = '{WR_RAMP, RAMP_HOLD};
                            n_phase        = PH_SETTLE;
                        end
                    end
                    PH_SETTLE: begin
                        if (w_wait_done) begin
                            o_bundle.wr[0]    = '{WR_XACT, i_actual_pos - i_latched_pos};
                            o_bundle.wr[1]    = '{WR_VMAX, 32'(i_cfg.run_speed)};
                            o_bundle.wr[2]    = '{WR_RAMP, RAMP_POSITION};
                            o_bundle.wr[3]    = '{WR_TGT, i_cfg.park_target};
                            o_bundle.last_idx = 2'd3;
                            n_phase           = PH_IDLE;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
                if (n_cnt != {COUNTER_BITS{1'b1}}) begin
                    n_cnt = n_cnt + 1'b1;
                end
            end
            KIND_START: n_phase = PH_START;
            KIND_MOVE: begin
                if (r_phase == PH_IDLE) begin
                    n_tgt          = i_move_target;
                    o_bundle.wr[0] = '{WR_TGT, i_move_target};
                end
            end
            default: begin
            end
        endcase
        o_bundle.busy    = (n_phase != PH_IDLE);
        o_bundle.cmd_pos = n_tgt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_tgt   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_tgt   <= n_tgt;
        end
    end

endmodule

// ===== sv/stepper_homing_sequencer_unit.sv =====
// The first result of a request is registered, valid the cycle after it is accepted.
// One result per cycle while o_res.ready is high; a request yielding n results
// (1 to 4) holds the result register, and the next request is taken as its last leaves.
// Reset (synchronous, active low): phase idle, tick counter and move target
// zero, config registers to their defaults, result register empty.
module stepper_homing_sequencer_unit
    import shs_pkg::*;
#(
    parameter int COUNTER_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    shs_req_if.sink               i_req,
    shs_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_bundle w_bundle, r_bundle;
    logic    r_valid;
    logic [1:0] r_idx;
    logic    w_accept, w_last, w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.homing_speed   <= RST_HOMING_SPEED;
            r_cfg.run_speed      <= RST_RUN_SPEED;
            r_cfg.backoff_target <= RST_BACKOFF_TARGET;
            r_cfg.search_target  <= RST_SEARCH_TARGET;
            r_cfg.park_target    <= RST_PARK_TARGET;
            r_cfg.wait_ticks     <= RST_WAIT_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HOMING_SPEED:   r_cfg.homing_speed   <= i_cfg_data[SPEED_W-1:0];
                CFG_RUN_SPEED:      r_cfg.run_speed      <= i_cfg_data[SPEED_W-1:0];
                CFG_BACKOFF_TARGET: r_cfg.backoff_target <= i_cfg_data;
                CFG_SEARCH_TARGET:  r_cfg.search_target  <= i_cfg_data;
                CFG_PARK_TARGET:    r_cfg.park_target    <= i_cfg_data;
                CFG_WAIT_TICKS:     r_cfg.wait_ticks     <= i_cfg_data[WAIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_last   = (r_idx == r_bundle.last_idx);
    assign w_take   = r_valid && o_res.ready;
    assign i_req.ready = !r_valid || (o_res.ready && w_last);
    assign w_accept = i_req.valid && i_req.ready;

    shs_step #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_step (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_kind          (i_req.kind),
        .i_move_target   (i_req.move_target),
        .i_at_left_stop  (i_req.at_left_stop),
        .i_speed_is_zero (i_req.speed_is_zero),
        .i_actual_pos    (i_req.actual_pos),
        .i_latched_pos   (i_req.latched_pos),
        .i_cfg           (r_cfg),
        .o_bundle        (w_bundle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (w_take) begin
            // advance to the next write, drop the bundle after its last
            if (w_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bundle <= w_bundle;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.write_reg     = r_bundle.wr[r_idx].reg_sel;
    assign o_res.write_value   = r_bundle.wr[r_idx].value;
    assign o_res.last          = w_last;
    assign o_res.homing_busy   = r_bundle.busy;
    assign o_res.commanded_pos = r_bundle.cmd_pos;

endmodule

// ===== sv/shs_checker.sv =====
// Port-level checks for the homing sequencer, bound to the top level.
// Depends on shs_pkg and the top-level ports.
module shs_checker
    import shs_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [2:0]         i_write_reg,
    input logic               i_last,
    input logic               i_homing_busy,
    input logic signed [31:0] i_commanded_pos
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // an accepted request shows its first result in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("no result after accepted request");

    // more results follow a non-final one, with unchanged status
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |=>
            i_out_valid && $stable(i_homing_busy) && $stable(i_commanded_pos))
        else $error("burst of one request broken");

    // no new request while a multi-result burst is still pending
    a_no_accept_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> !i_in_ready)
        else $error("request accepted during burst");

    a_reg_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_write_reg == WR_NONE || i_write_reg == WR_VMAX ||
                         i_write_reg == WR_TGT || i_write_reg == WR_RAMP ||
                         i_write_reg == WR_XACT))
        else $error("illegal write register code");

endmodule

bind stepper_homing_sequencer_unit shs_checker u_shs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_write_reg     (o_res.write_reg),
    .i_last          (o_res.last),
    .i_homing_busy   (o_res.homing_busy),
    .i_commanded_pos (o_res.commanded_pos)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for stepper_homing_sequencer_unit: predicts the
// register writes of every request and checks each result in order.
// Depends on shs_pkg, shs_req_if, shs_res_if and the unit itself.
module testbench;
    import shs_pkg::*;

    localparam int CNT_BITS = 16;
    localparam logic [CNT_BITS-1:0] CNT_FULL = '1;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_PCT = 17;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [2:0] {
        HOME_IDLE,
        HOME_ARMED,
        HOME_BACKOFF,
        HOME_SEARCH,
        HOME_SETTLE
    } t_home_phase;

    typedef struct packed {
        t_wreg       wreg;
        logic [31:0] value;
        logic        last;
        logic        busy;
        logic [31:0] cmd_pos;
    } t_reg_write;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    shs_req_if req_ch ();
    shs_res_if res_ch ();

    stepper_homing_sequencer_unit #(
        .COUNTER_BITS(CNT_BITS)
    ) uut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_req     (req_ch),
        .o_res     (res_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    // Predicted sequencer state and settings
    t_home_phase         phase_q;
    logic [CNT_BITS-1:0] tick_cnt;
    logic [31:0]         cmd_pos_q;
    logic [SPEED_W-1:0]  homing_spd;
    logic [SPEED_W-1:0]  run_spd;
    logic [31:0]         backoff_pos;
    logic [31:0]         search_pos;
    logic [31:0]         park_pos;
    logic [WAIT_W-1:0]   wait_limit;

    t_reg_write pending_writes[$];
    t_reg_write expected_w;
    int         error_cnt;
    int         cycle_cnt;
    logic       stalls_on;
    logic       gaps_on;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge clk) begin
        res_ch.ready <= !stalls_on || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_writes.size() == 0) begin
                $error("unexpected result: write_reg %0d write_value %h",
                       res_ch.write_reg, res_ch.write_value);
                error_cnt++;
            end else begin
                expected_w = pending_writes.pop_front();
                if (res_ch.write_reg !== expected_w.wreg) begin
                    $error("write_reg: expected %0d, got %0d", expected_w.wreg,
                           res_ch.write_reg);
                    error_cnt++;
                end
                if (res_ch.write_value !== expected_w.value) begin
                    $error("write_value: expected %h, got %h", expected_w.value,
                           res_ch.write_value);
                    error_cnt++;
                end
                if (res_ch.last !== expected_w.last) begin
                    $error("last: expected %b, got %b", expected_w.last, res_ch.last);
                    error_cnt++;
                end
                if (res_ch.homing_busy !== expected_w.busy) begin
                    $error("homing_busy: expected %b, got %b", expected_w.busy,
                           res_ch.homing_busy);
                    error_cnt++;
                end
                if (res_ch.commanded_pos !== expected_w.cmd_pos) begin
                    $error("commanded_pos: expected %h, got %h", expected_w.cmd_pos,
                           res_ch.commanded_pos);
                    error_cnt++;
                end
            end
        end
    end

    task automatic predict_writes(input logic [1:0] kind, input logic [31:0] move_pos,
                                  input logic stop, input logic zero_vel,
                                  input logic [31:0] act, input logic [31:0] lat);
        t_wreg       regs[$];
        logic [31:0] vals[$];
        if (kind == KIND_TICK) begin
            case (phase_q)
                HOME_IDLE: ;
                HOME_ARMED: begin
                    regs.push_back(WR_VMAX);
                    vals.push_back(32'(homing_spd));
                    if (stop) begin
                        tick_cnt = '0;
                        regs.push_back(WR_TGT);
                        vals.push_back(backoff_pos);
                    end else if (wait_limit < CNT_FULL) begin
                        tick_cnt = CNT_BITS'(wait_limit);
                    end else begin
                        tick_cnt = CNT_FULL;
                    end
                    phase_q = HOME_BACKOFF;
                end
                HOME_BACKOFF: begin
                    if (tick_cnt > wait_limit) begin
                        regs.push_back(WR_TGT);
                        vals.push_back(search_pos);
                        tick_cnt = '0;
                        phase_q = HOME_SEARCH;
                    end
                end
                HOME_SEARCH: begin
                    if (zero_vel) begin
                        tick_cnt = '0;
                        regs.push_back(WR_RAMP);
                        vals.push_back(RAMP_HOLD);
                        phase_q = HOME_SETTLE;
                    end
                end
                HOME_SETTLE: begin
                    if (tick_cnt > wait_limit) begin
                        regs.push_back(WR_XACT);
                        vals.push_back(act - lat);
                        regs.push_back(WR_VMAX);
                        vals.push_back(32'(run_spd));
                        regs.push_back(WR_RAMP);
                        vals.push_back(RAMP_POSITION);
                        regs.push_back(WR_TGT);
                        vals.push_back(park_pos);
                        phase_q = HOME_IDLE;
                    end
                end
                default: phase_q = HOME_IDLE;
            endcase
            // saturate, never wrap
            if (tick_cnt != CNT_FULL) tick_cnt++;
        end else if (kind == KIND_START) begin
            phase_q = HOME_ARMED;
        end else if (kind == KIND_MOVE) begin
            if (phase_q == HOME_IDLE) begin
                cmd_pos_q = move_pos;
                regs.push_back(WR_TGT);
                vals.push_back(move_pos);
            end
        end
        if (regs.size() == 0) begin
            regs.push_back(WR_NONE);
            vals.push_back('0);
        end
        foreach (regs[k]) begin
            pending_writes.push_back('{wreg: regs[k], value: vals[k],
                                       last: (k == regs.size() - 1),
                                       busy: (phase_q != HOME_IDLE),
                                       cmd_pos: cmd_pos_q});
        end
    endtask

    task automatic send_request(input logic [1:0] kind, input logic [31:0] move_pos,
                                input logic stop, input logic zero_vel,
                                input logic [31:0] act, input logic [31:0] lat);
        @(negedge clk);
        if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= kind;
        req_ch.move_target   <= move_pos;
        req_ch.at_left_stop  <= stop;
        req_ch.speed_is_zero <= zero_vel;
        req_ch.actual_pos    <= act;
        req_ch.latched_pos   <= lat;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        predict_writes(kind, move_pos, stop, zero_vel, act, lat);
    endtask

    task automatic send_tick(input logic stop, input logic zero_vel);
        send_request(KIND_TICK, $urandom, stop, zero_vel, $urandom, $urandom);
    endtask

    task automatic send_other(input logic [1:0] kind);
        send_request(kind, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     $urandom, $urandom);
    endtask

    // Drop the request and hold until every predicted write has come back.
    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [31:0] hs, input logic [31:0] rs,
                                  input logic [31:0] bo, input logic [31:0] sp,
                                  input logic [31:0] pk, input logic [31:0] wt);
        cfg_write(CFG_HOMING_SPEED, hs);
        cfg_write(CFG_RUN_SPEED, rs);
        cfg_write(CFG_BACKOFF_TARGET, bo);
        cfg_write(CFG_SEARCH_TARGET, sp);
        cfg_write(CFG_PARK_TARGET, pk);
        cfg_write(CFG_WAIT_TICKS, wt);
        @(negedge clk);
        cfg_we      <= 1'b0;
        homing_spd  = hs[SPEED_W-1:0];
        run_spd     = rs[SPEED_W-1:0];
        backoff_pos = bo;
        search_pos  = sp;
        park_pos    = pk;
        wait_limit  = wt[WAIT_W-1:0];
    endtask

    // Idle behavior: ticks without writes, move extremes, unused kind, then a
    // start on the switch with the reset settings and a move that is ignored.
    task automatic test_idle_requests();
        send_tick(1'b1, 1'b1);
        send_request(KIND_MOVE, 32'h7FFF_FFFF, 1'b0, 1'b0, '0, '0);
        send_request(KIND_MOVE, 32'h8000_0000, 1'b1, 1'b1, '1, '1);
        send_other(KIND_UNUSED);
        send_other(KIND_START);
        send_tick(1'b1, 1'b0);
        send_request(KIND_MOVE, 32'h1234_5678, 1'b0, 1'b0, '0, '0);
        drain_results();
    endtask

    // Full run starting on the switch, extreme settings, wrapping rebase.
    task automatic test_homing_on_switch();
        apply_settings(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'hFFFF_FFFF, 32'h0);
        send_other(KIND_START);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_request(KIND_MOVE, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_request(KIND_TICK, '0, 1'b0, 1'b0, 32'h8000_0000, 32'h0000_0001);
        send_tick(1'b0, 1'b0);
        drain_results();
    endtask

    // Saturated counter with the largest wait, restart while homing, then
    // release the wait phases by lowering the limit.
    task automatic test_restart_and_saturation();
        apply_settings(32'd4000, 32'd100000, 32'd1000, -32'sd30000, 32'd6800,
                       32'h0000_FFFF);
        send_other(KIND_START);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_other(KIND_START);
        send_tick(1'b1, 1'b1);
        drain_results();
        apply_settings(32'h0, 32'h007F_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF,
                       32'h0000_FFFE);
        send_other(KIND_START);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        drain_results();
        apply_settings(32'h0, 32'h007F_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF,
                       32'h0000_0001);
        send_tick(1'b0, 1'b0);
        send_request(KIND_MOVE, 32'h0, 1'b0, 1'b0, '0, '0);
        drain_results();
    endtask

    // Mostly well-formed homing runs with random content, plus noise.
    task automatic test_random_traffic(input int n_items, input logic idle_en,
                                       input int max_wait);
        int sent;
        int steps;
        int roll;
        apply_settings($urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom_range(max_wait));
        stalls_on = idle_en;
        gaps_on   = idle_en;
        sent      = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 80) begin
                send_other(KIND_START);
                sent++;
                steps = 0;
                while (phase_q != HOME_IDLE && steps < 24 && sent < n_items) begin
                    roll = $urandom_range(99);
                    if (roll < 6) send_other(KIND_MOVE);
                    else if (roll < 9) send_other(KIND_START);
                    else if (roll < 11) send_other(KIND_UNUSED);
                    else send_tick(1'($urandom_range(1)), ($urandom_range(99) < 35));
                    sent++;
                    steps++;
                end
                if ($urandom_range(1)) begin
                    send_other(KIND_MOVE);
                    sent++;
                end
            end else begin
                send_other(2'($urandom_range(3)));
                sent++;
            end
        end
        drain_results();
        stalls_on = 1'b1;
        gaps_on   = 1'b1;
    endtask

    initial begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = '0;
        cfg_data             = '0;
        req_ch.valid         = 1'b0;
        req_ch.kind          = '0;
        req_ch.move_target   = '0;
        req_ch.at_left_stop  = 1'b0;
        req_ch.speed_is_zero = 1'b0;
        req_ch.actual_pos    = '0;
        req_ch.latched_pos   = '0;
        res_ch.ready         = 1'b0;
        error_cnt            = 0;
        cycle_cnt            = 0;
        stalls_on            = 1'b1;
        gaps_on              = 1'b1;
        phase_q              = HOME_IDLE;
        tick_cnt             = '0;
        cmd_pos_q            = '0;
        homing_spd           = RST_HOMING_SPEED;
        run_spd              = RST_RUN_SPEED;
        backoff_pos          = RST_BACKOFF_TARGET;
        search_pos           = RST_SEARCH_TARGET;
        park_pos             = RST_PARK_TARGET;
        wait_limit           = RST_WAIT_TICKS;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_requests();
        test_homing_on_switch();
        test_restart_and_saturation();
        test_random_traffic(25, 1'b1, 3);
        test_random_traffic(25, 1'b0, 0);
        test_random_traffic(25, 1'b1, 5);

        drain_results();
        if (error_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== stepper_homing_sequencer_unit.f =====
sv/shs_pkg.sv
sv/shs_req_if.sv
sv/shs_res_if.sv
sv/shs_step.sv
sv/stepper_homing_sequencer_unit.sv
sv/shs_checker.sv
verif/testbench.sv
